// ===== hw/rtl/alu8_add_sub_booth_mul_restoring_div_assert.svh =====
// Assertion macros for the 8-bit ALU pipeline.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ALU8_ADD_SUB_BOOTH_MUL_RESTORING_DIV_ASSERT_SVH
`define ALU8_ADD_SUB_BOOTH_MUL_RESTORING_DIV_ASSERT_SVH

// Same-cycle implication.
`define ALU8_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alu8 assertion failed");

// Next-cycle implication.
`define ALU8_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alu8 assertion failed");

`endif

// ===== hw/rtl/alu8_pkg.sv =====
// Shared types and codes for the 8-bit ALU pipeline.
// No dependencies.
package alu8_pkg;

	localparam int DataW = 8;
	localparam int OpW   = 2;

	localparam logic [OpW-1:0] OP_ADD = 2'd0;
	localparam logic [OpW-1:0] OP_SUB = 2'd1;
	localparam logic [OpW-1:0] OP_MUL = 2'd2;
	localparam logic [OpW-1:0] OP_DIV = 2'd3;

	// Work word handed from cell to cell.
	typedef struct packed {
		logic [OpW-1:0]   op;
		logic [DataW-1:0] a;       // Booth A, divide remainder, or add/sub result
		logic [DataW-1:0] q;       // multiplier / quotient register
		logic             qm1;     // Booth Q-1 bit
		logic [DataW-1:0] m;       // multiplicand or divisor magnitude
		logic             skip;    // add, subtract or divide by zero: cells pass through
		logic             neg_dvd;
		logic             neg_dvs;
		logic             ovf;
	} stage_t;

endpackage

// ===== hw/rtl/alu8_pre.sv =====
// Front stage: decodes one input beat into the cell work word.
// Depends on alu8_pkg.
module alu8_pre (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [alu8_pkg::OpW-1:0]   opcode,
	input  logic [alu8_pkg::DataW-1:0] operand_a,
	input  logic [alu8_pkg::DataW-1:0] operand_b,
	output logic                  out_valid,
	output alu8_pkg::stage_t      out_stage
);

	logic             valid_q;
	alu8_pkg::stage_t stage_q;
	alu8_pkg::stage_t nxt;
	logic [alu8_pkg::DataW:0]   sum9;
	logic [alu8_pkg::DataW:0]   dif9;
	logic [alu8_pkg::DataW-1:0] a_mag;
	logic [alu8_pkg::DataW-1:0] b_mag;

	always_comb begin
		sum9  = {operand_a[7], operand_a} + {operand_b[7], operand_b};
		dif9  = {operand_a[7], operand_a} - {operand_b[7], operand_b};
		a_mag = operand_a[7] ? (8'd0 - operand_a) : operand_a;
		b_mag = operand_b[7] ? (8'd0 - operand_b) : operand_b;

		nxt         = '0;
		nxt.op      = opcode;
		unique case (opcode)
			alu8_pkg::OP_ADD: begin
				nxt.a    = sum9[7:0];
				nxt.ovf  = sum9[8] ^ sum9[7];
				nxt.skip = 1'b1;
			end
			alu8_pkg::OP_SUB: begin
				nxt.a    = dif9[7:0];
				nxt.ovf  = dif9[8] ^ dif9[7];
				nxt.skip = 1'b1;
			end
			alu8_pkg::OP_MUL: begin
				nxt.q = operand_a;
				nxt.m = operand_b;
			end
			default: begin
				nxt.neg_dvd = operand_a[7];
				nxt.neg_dvs = operand_b[7];
				nxt.m       = b_mag;
				if (b_mag == 8'd0) begin
					nxt.skip = 1'b1;
					nxt.a    = a_mag;
					nxt.q    = 8'd1;
				end else begin
					nxt.q    = a_mag;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_stage = stage_q;

endmodule

// ===== hw/rtl/alu8_cell.sv =====
// One step cell: a Booth step or a restoring divide step per cycle while en is high, or a pass-through on skip.
// Depends on alu8_pkg.
module alu8_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  alu8_pkg::stage_t in_stage,
	output logic             out_valid,
	output alu8_pkg::stage_t out_stage
);

	logic             valid_q;
	alu8_pkg::stage_t stage_q;
	alu8_pkg::stage_t nxt;
	logic [alu8_pkg::DataW-1:0] booth_a;
	logic [alu8_pkg::DataW-1:0] div_a;
	logic [alu8_pkg::DataW-1:0] div_d;

	always_comb begin
		nxt = in_stage;

		// Booth: add or subtract the multiplicand, then arithmetic shift A:Q.
		if (in_stage.q[0] && !in_stage.qm1) begin
			booth_a = in_stage.a - in_stage.m;
		end else if (!in_stage.q[0] && in_stage.qm1) begin
			booth_a = in_stage.a + in_stage.m;
		end else begin
			booth_a = in_stage.a;
		end

		// Restoring divide: shift A:Q left, trial subtract, keep on non-negative.
		div_a = {in_stage.a[6:0], in_stage.q[7]};
		div_d = div_a - in_stage.m;

		if (!in_stage.skip) begin
			if (in_stage.op == alu8_pkg::OP_MUL) begin
				nxt.qm1 = in_stage.q[0];
				nxt.q   = {booth_a[0], in_stage.q[7:1]};
				nxt.a   = {booth_a[7], booth_a[7:1]};
			end else begin
				nxt.q = {in_stage.q[6:0], ~div_d[7]};
				nxt.a = div_d[7] ? div_a : div_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_stage = stage_q;

endmodule

// ===== hw/rtl/alu8_post.sv =====
// Back stage: divide sign fixes and the output register.
// Depends on alu8_pkg.
module alu8_post (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  alu8_pkg::stage_t in_stage,
	output logic             out_valid,
	output logic [23:0]      out_tdata
);

	logic       valid_q;
	logic [7:0] acc_q;
	logic [7:0] aux_q;
	logic       ovf_q;
	logic [7:0] acc_d;
	logic [7:0] aux_d;

	always_comb begin
		acc_d = in_stage.a;
		aux_d = in_stage.q;
		if (in_stage.op == alu8_pkg::OP_DIV) begin
			if (in_stage.neg_dvd) begin
				acc_d = 8'd0 - in_stage.a;
			end
			if (in_stage.neg_dvd ^ in_stage.neg_dvs) begin
				aux_d = 8'd0 - in_stage.q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= acc_d;
			aux_q <= aux_d;
			ovf_q <= in_stage.ovf;
		end
	end

	assign out_valid = valid_q;
	assign out_tdata = {7'd0, ovf_q, aux_q, acc_q};

endmodule

// ===== hw/rtl/alu8_add_sub_booth_mul_restoring_div.sv =====
// 8-bit signed ALU: add, subtract, Booth multiply, restoring divide.
// Depends on alu8_pkg, alu8_pre, alu8_cell, alu8_post and the assert header.
//
// One operation per beat, accepted every cycle unless the output stalls;
// each result passes the decode stage, eight step cells and the output
// register in turn, one Booth or shift-subtract step in each step cell.
// The whole pipe holds while a result waits on m_axis_tready, empty stages
// included, so no beat is lost or repeated.
// Input tdata: [1:0] opcode, [9:2] operand_a, [17:10] operand_b.
// Output tdata: [7:0] acc_out, [15:8] aux_out, [16] overflow.
`include "alu8_add_sub_booth_mul_restoring_div_assert.svh"

module alu8_add_sub_booth_mul_restoring_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // opcode, operand_a, operand_b
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // acc_out, aux_out, overflow
);

	localparam int Cells = 8;

	logic             en;
	logic             cell_valid [0:Cells];
	alu8_pkg::stage_t cell_stage [0:Cells];

	// Advance whenever the output slot is free or being taken.
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	alu8_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.opcode    (s_axis_tdata[1:0]),
		.operand_a (s_axis_tdata[9:2]),
		.operand_b (s_axis_tdata[17:10]),
		.out_valid (cell_valid[0]),
		.out_stage (cell_stage[0])
	);

	for (genvar i = 0; i < Cells; i++) begin : g_cell
		alu8_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cell_valid[i]),
			.in_stage  (cell_stage[i]),
			.out_valid (cell_valid[i+1]),
			.out_stage (cell_stage[i+1])
		);
	end

	alu8_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cell_valid[Cells]),
		.in_stage  (cell_stage[Cells]),
		.out_valid (m_axis_tvalid),
		.out_tdata (m_axis_tdata)
	);

	`ALU8_ASSERT_NEXT(a_accept_fills_pre, s_axis_tvalid && s_axis_tready, cell_valid[0])
	`ALU8_ASSERT_NEXT(a_addsub_aux_zero,
		en && cell_valid[Cells] && (cell_stage[Cells].op == alu8_pkg::OP_ADD ||
		cell_stage[Cells].op == alu8_pkg::OP_SUB),
		m_axis_tdata[15:8] == 8'd0)
	`ALU8_ASSERT_NEXT(a_div_zero_quotient,
		en && cell_valid[Cells] && cell_stage[Cells].op == alu8_pkg::OP_DIV &&
		cell_stage[Cells].m == 8'd0,
		m_axis_tdata[15:8] == 8'h01 || m_axis_tdata[15:8] == 8'hFF)
	`ALU8_ASSERT_NEXT(a_mul_no_ovf,
		en && cell_valid[Cells] && (cell_stage[Cells].op == alu8_pkg::OP_MUL ||
		cell_stage[Cells].op == alu8_pkg::OP_DIV),
		!m_axis_tdata[16])

endmodule
